### sv/suvt_pkg.sv
// Shared types and codes for the sorted unique value table.
`timescale 1ns / 1ps
`default_nettype none

package suvt_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_INSERT    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DUMP_ASC  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DUMP_DESC = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_QUERY     = 3'd4;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_FULL      = 3'd4,
    ST_ELEMENT   = 3'd5,
    ST_NONE      = 3'd6
  } status_e;

endpackage

`default_nettype wire

### sv/suvt_if.sv
// Valid/ready channel interfaces for request and result words.
`timescale 1ns / 1ps
`default_nettype none

interface suvt_req_if;
  logic                                valid;
  logic                                ready;
  logic [suvt_pkg::ACTION_W-1:0]       action;
  logic signed [suvt_pkg::VALUE_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface suvt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [suvt_pkg::STATUS_W-1:0]       status;
  logic signed [suvt_pkg::VALUE_W-1:0] element;
  logic                                last;

  modport source (output valid, status, element, last, input ready);
  modport sink   (input valid, status, element, last, output ready);
endinterface

`default_nettype wire

### sv/sorted_unique_value_table_top.sv
// Top level: sorted table of distinct signed values in a single-port memory.
//
// Usage: requests arrive on in_i (action, value) and results leave on out_o
// (status, element, last); both are valid/ready channels, a word moves at a
// clock edge with valid and ready high. Each request yields one or more result
// words, the final one flagged by last.
// Insert and delete scan the table from index 0 to the sorted position, then
// move the entries behind it by one place, and the status word follows.
// Dumps give one word per entry; the neighbour query gives its matches, or a
// status word with no match or below three entries. Each entry is read in one
// state and used in the next because the table sits in one memory with one
// port and a registered read: a read step, then a use step.
// The next request is taken at the edge after the final word is registered.
// When the receiver stalls, a step that must load a result word holds in place
// until the result register frees up.
// Reset empties the table (entry count to zero) at once; memory contents are
// not cleared and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_value_table_top #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  suvt_req_if.sink         in_i,
  suvt_rsp_if.source       out_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned VW = suvt_pkg::VALUE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_CHK, S_DECIDE,
    S_INS_RD, S_INS_SH, S_INS_WR,
    S_DEL_RD, S_DEL_SH,
    S_DUMP_RD, S_DUMP_EM,
    S_Q_RD, S_Q_CHK, S_Q_END,
    S_RESP
  } state_e;

  state_e                         state_q;
  logic [suvt_pkg::ACTION_W-1:0]  action_q;
  logic signed [VW-1:0]           value_q;
  logic [CW-1:0]                  count_q;
  logic [AW-1:0]                  idx_q;
  logic [CW-1:0]                  pos_q;
  logic                           found_q;
  logic [CW-1:0]                  cnt_q;
  suvt_pkg::status_e              resp_q;
  logic signed [VW-1:0]           prev_q;
  logic signed [VW-1:0]           cur_q;
  logic                           pend_q;
  logic signed [VW-1:0]           pend_val_q;

  logic                           out_valid_q;
  suvt_pkg::status_e              out_status_q;
  logic signed [VW-1:0]           out_elem_q;
  logic                           out_last_q;

  // Table memory
  logic signed [VW-1:0]           mem [CAPACITY];
  logic signed [VW-1:0]           rd_data_q;
  logic                           mem_re;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic signed [VW-1:0]           mem_wdata;

  logic                           can_emit;
  logic                           emit;
  logic [CW-1:0]                  idx_ext;
  logic                           idx_at_end;
  logic signed [VW:0]             nb_sum;
  logic signed [VW:0]             nb_twice;
  logic                           nb_match;

  assign can_emit   = !out_valid_q || out_o.ready;
  assign idx_ext    = CW'(idx_q);
  assign idx_at_end = (idx_ext + CW'(1)) == count_q;

  // Neighbour test: prev + next == 2 * cur, exact in 33 bits
  assign nb_sum   = {prev_q[VW-1], prev_q} + {rd_data_q[VW-1], rd_data_q};
  assign nb_twice = {cur_q, 1'b0};
  assign nb_match = (idx_ext >= CW'(2)) && (nb_sum == nb_twice);

  // A new result word is loaded this cycle
  assign emit = can_emit && ((state_q == S_DUMP_EM) || (state_q == S_RESP) ||
                             (state_q == S_Q_END && pend_q) ||
                             (state_q == S_Q_CHK && nb_match && pend_q));

  // Memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = rd_data_q;
    unique case (state_q) inside
      S_FIND_RD, S_INS_RD, S_DEL_RD, S_DUMP_RD, S_Q_RD: mem_re = 1'b1;
      S_INS_SH: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q + AW'(1);
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = value_q;
      end
      S_DEL_SH: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q - AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[idx_q];
    end
  end

  // Sequencer with result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      action_q     <= '0;
      value_q      <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      found_q      <= 1'b0;
      cnt_q        <= '0;
      resp_q       <= suvt_pkg::ST_NONE;
      prev_q       <= '0;
      cur_q        <= '0;
      pend_q       <= 1'b0;
      pend_val_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= suvt_pkg::ST_NONE;
      out_elem_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_o.ready && !emit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            action_q <= in_i.action;
            value_q  <= in_i.value;
            idx_q    <= '0;
            cnt_q    <= '0;
            pend_q   <= 1'b0;
            resp_q   <= suvt_pkg::ST_NONE;
            unique case (in_i.action) inside
              suvt_pkg::ACT_INSERT, suvt_pkg::ACT_DELETE: begin
                if (count_q == '0) begin
                  pos_q   <= '0;
                  found_q <= 1'b0;
                  state_q <= S_DECIDE;
                end else begin
                  state_q <= S_FIND_RD;
                end
              end
              suvt_pkg::ACT_DUMP_ASC, suvt_pkg::ACT_DUMP_DESC: begin
                if (count_q == '0) begin
                  state_q <= S_RESP;
                end else begin
                  if (in_i.action == suvt_pkg::ACT_DUMP_DESC) begin
                    idx_q <= AW'(count_q - CW'(1));
                  end
                  state_q <= S_DUMP_RD;
                end
              end
              suvt_pkg::ACT_QUERY: begin
                state_q <= (count_q < CW'(3)) ? S_RESP : S_Q_RD;
              end
              default: state_q <= S_RESP;
            endcase
          end
        end

        // Linear search for the first entry >= value
        S_FIND_RD: state_q <= S_FIND_CHK;
        S_FIND_CHK: begin
          if (rd_data_q >= value_q) begin
            pos_q   <= idx_ext;
            found_q <= (rd_data_q == value_q);
            state_q <= S_DECIDE;
          end else if (idx_at_end) begin
            pos_q   <= count_q;
            found_q <= 1'b0;
            state_q <= S_DECIDE;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_FIND_RD;
          end
        end

        S_DECIDE: begin
          if (action_q == suvt_pkg::ACT_INSERT) begin
            if (found_q) begin
              resp_q  <= suvt_pkg::ST_DUPLICATE;
              state_q <= S_RESP;
            end else if (count_q >= CW'(CAPACITY)) begin
              resp_q  <= suvt_pkg::ST_FULL;
              state_q <= S_RESP;
            end else if (pos_q == count_q) begin
              state_q <= S_INS_WR;
            end else begin
              idx_q   <= AW'(count_q - CW'(1));
              state_q <= S_INS_RD;
            end
          end else begin
            if (!found_q) begin
              resp_q  <= suvt_pkg::ST_NOTFOUND;
              state_q <= S_RESP;
            end else if ((pos_q + CW'(1)) == count_q) begin
              count_q <= count_q - CW'(1);
              resp_q  <= suvt_pkg::ST_DELETED;
              state_q <= S_RESP;
            end else begin
              idx_q   <= AW'(pos_q + CW'(1));
              state_q <= S_DEL_RD;
            end
          end
        end

        // Insert: move entries up from the top down to the position
        S_INS_RD: state_q <= S_INS_SH;
        S_INS_SH: begin
          if (idx_ext == pos_q) begin
            state_q <= S_INS_WR;
          end else begin
            idx_q   <= idx_q - AW'(1);
            state_q <= S_INS_RD;
          end
        end
        S_INS_WR: begin
          count_q <= count_q + CW'(1);
          resp_q  <= suvt_pkg::ST_INSERTED;
          state_q <= S_RESP;
        end

        // Delete: move entries behind the position down by one
        S_DEL_RD: state_q <= S_DEL_SH;
        S_DEL_SH: begin
          if (idx_at_end) begin
            count_q <= count_q - CW'(1);
            resp_q  <= suvt_pkg::ST_DELETED;
            state_q <= S_RESP;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_DEL_RD;
          end
        end

        // Dumps: one result word per entry
        S_DUMP_RD: state_q <= S_DUMP_EM;
        S_DUMP_EM: begin
          if (can_emit) begin
            out_valid_q  <= 1'b1;
            out_status_q <= suvt_pkg::ST_ELEMENT;
            out_elem_q   <= rd_data_q;
            out_last_q   <= (cnt_q + CW'(1)) == count_q;
            if ((cnt_q + CW'(1)) == count_q) begin
              state_q <= S_IDLE;
            end else begin
              cnt_q   <= cnt_q + CW'(1);
              idx_q   <= (action_q == suvt_pkg::ACT_DUMP_DESC) ? idx_q - AW'(1)
                                                              : idx_q + AW'(1);
              state_q <= S_DUMP_RD;
            end
          end
        end

        // Neighbour query: a match is held back one step so last can be set
        S_Q_RD: state_q <= S_Q_CHK;
        S_Q_CHK: begin
          if (!(nb_match && pend_q && !can_emit)) begin
            if (nb_match) begin
              if (pend_q) begin
                out_valid_q  <= 1'b1;
                out_status_q <= suvt_pkg::ST_ELEMENT;
                out_elem_q   <= pend_val_q;
                out_last_q   <= 1'b0;
              end
              pend_q     <= 1'b1;
              pend_val_q <= cur_q;
            end
            prev_q <= cur_q;
            cur_q  <= rd_data_q;
            if (idx_at_end) begin
              state_q <= S_Q_END;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= S_Q_RD;
            end
          end
        end
        S_Q_END: begin
          if (!pend_q) begin
            resp_q  <= suvt_pkg::ST_NONE;
            state_q <= S_RESP;
          end else if (can_emit) begin
            out_valid_q  <= 1'b1;
            out_status_q <= suvt_pkg::ST_ELEMENT;
            out_elem_q   <= pend_val_q;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end

        // Single status word echoing the request value
        S_RESP: begin
          if (can_emit) begin
            out_valid_q  <= 1'b1;
            out_status_q <= resp_q;
            out_elem_q   <= value_q;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_status_q;
  assign out_o.element = out_elem_q;
  assign out_o.last    = out_last_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("table written while idle");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CW'(mem_waddr) <= count_q) && (count_q < CW'(CAPACITY) || state_q == S_DEL_SH))
    else $error("table write outside the filled range");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_WR) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the table");

endmodule

`default_nettype wire
